>>> design/bpc_pkg.sv
package bpc_pkg;

    localparam int ENTRIES_DEFAULT      = 16;
    localparam int PAGE_SECTORS_DEFAULT = 8;

    // Wide enough for the sector offset at the largest supported page.
    localparam int OFFSET_W = 7;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_DROP  = 2'd3;

    localparam logic [2:0] KIND_WRITE_BACK = 3'd0;
    localparam logic [2:0] KIND_FILL       = 3'd1;
    localparam logic [2:0] KIND_TRANSFER   = 3'd2;
    localparam logic [2:0] KIND_DONE       = 3'd3;
    localparam logic [2:0] KIND_ERROR      = 3'd4;

    typedef enum logic [1:0] {
        LS_EMPTY = 2'd0,
        LS_CLEAN = 2'd1,
        LS_DIRTY = 2'd2
    } line_state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] disk_id;
        logic [31:0] lba;
        logic [7:0]  num_sectors;
        logic [31:0] device_sectors;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] out_device_id;
        logic [31:0] page_first;
        logic [3:0]  count;
        logic [2:0]  page_offset;
        logic [4:0]  dirty_entries;
        logic        last;
    } result_t;

    // Request after the front end has split the address into page and offset.
    typedef struct packed {
        logic [1:0]          operation;
        logic [31:0]         disk_id;
        logic [31:0]         page;
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          num_sectors;
        logic [31:0]         device_sectors;
    } req_t;

endpackage

>>> design/block_page_cache_controller.sv
// Tag and state engine of a fully associative write-back sector cache.
// A request (read, write, flush or drop) is taken on cmd at a clock edge
// where start is high and busy is low. Results leave on result, each valid
// for exactly one cycle while result_valid is high; the receiver must take
// them as they come. The final result of a request has last set, and every
// result of a request carries the dirty entry count after that request.
// A front end splits the address into page and offset and feeds a
// two-entry queue; the back end then does the tag compare, then the
// planning, and then emits the results. A flush visits every entry in
// turn before its done result. The front may accept new requests while
// the back end still emits.
// Reset empties all entries, zeroes the replacement pointer and the dirty
// count, and drops anything queued.
module block_page_cache_controller #(
    parameter int ENTRIES      = bpc_pkg::ENTRIES_DEFAULT,
    parameter int PAGE_SECTORS = bpc_pkg::PAGE_SECTORS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bpc_pkg::cmd_t     cmd,
    output logic              result_valid,
    output bpc_pkg::result_t  result
);

    logic          push, full, pop, q_valid;
    bpc_pkg::req_t push_data, q_head;

    bpc_front #(
        .PAGE_SECTORS (PAGE_SECTORS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    bpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    bpc_back #(
        .ENTRIES      (ENTRIES),
        .PAGE_SECTORS (PAGE_SECTORS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

>>> design/bpc_front.sv
module bpc_front #(
    parameter int PAGE_SECTORS = bpc_pkg::PAGE_SECTORS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  bpc_pkg::cmd_t  cmd,
    input  logic           full,
    output logic           push,
    output bpc_pkg::req_t  push_data
);

    localparam bit          IS_POW2 = ((PAGE_SECTORS & (PAGE_SECTORS - 1)) == 0);
    localparam int          RW      = $clog2(PAGE_SECTORS + 1) + 1;
    localparam logic [31:0] MASK    = 32'(PAGE_SECTORS - 1);
    localparam logic [3:0]  STEPS   = 4'd8;

    bpc_pkg::cmd_t   hold_reg;
    logic            stage_valid_reg;
    logic [3:0]      steps_reg;
    logic [RW-1:0]   rem_reg;
    logic [RW-1:0]   rem_next;
    logic [4:0]      nib_lo;
    logic [3:0]      nibble;
    logic            done;
    logic            accept;
    logic [31:0]     rem32;

    assign done   = stage_valid_reg && (IS_POW2 || (steps_reg == STEPS));
    assign push   = done && !full;
    assign busy   = stage_valid_reg && !push;
    assign accept = start && !busy;

    // Remainder by a page size that is not a power of two: four bits per cycle.
    always_comb
    begin
        rem_next = rem_reg;
        nib_lo   = 5'd28 - {steps_reg[2:0], 2'b00};
        nibble   = hold_reg.lba[nib_lo +: 4];
        for (int k = 3; k >= 0; k--)
        begin
            rem_next = {rem_next[RW-2:0], nibble[k]};
            if (rem_next >= RW'(PAGE_SECTORS))
            begin
                rem_next = rem_next - RW'(PAGE_SECTORS);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            steps_reg       <= '0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
            steps_reg       <= '0;
        end
        else if (push)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (stage_valid_reg && !done)
        begin
            steps_reg <= steps_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= cmd;
            rem_reg  <= '0;
        end
        else if (stage_valid_reg && !done)
        begin
            rem_reg <= rem_next;
        end
    end

    assign rem32 = IS_POW2 ? (hold_reg.lba & MASK) : 32'(rem_reg);

    always_comb
    begin
        push_data.operation      = hold_reg.operation;
        push_data.disk_id        = hold_reg.disk_id;
        push_data.page           = hold_reg.lba - rem32;
        push_data.offset         = bpc_pkg::OFFSET_W'(rem32);
        push_data.num_sectors    = hold_reg.num_sectors;
        push_data.device_sectors = hold_reg.device_sectors;
    end

endmodule

>>> design/bpc_queue.sv
module bpc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bpc_pkg::req_t  push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output bpc_pkg::req_t  head
);

    bpc_pkg::req_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    fill_reg;

    assign full  = (fill_reg == 2'd2);
    assign valid = (fill_reg != 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/bpc_back.sv
module bpc_back #(
    parameter int ENTRIES      = bpc_pkg::ENTRIES_DEFAULT,
    parameter int PAGE_SECTORS = bpc_pkg::PAGE_SECTORS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  bpc_pkg::req_t     q_head,
    output logic              pop,
    output logic              result_valid,
    output bpc_pkg::result_t  result
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(PAGE_SECTORS + 1);
    localparam int DW = $clog2(ENTRIES + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOOK  = 9'b000000010,
        S_PLAN  = 9'b000000100,
        S_VWB   = 9'b000001000,
        S_FILL  = 9'b000010000,
        S_ERR   = 9'b000100000,
        S_XFER  = 9'b001000000,
        S_WALK  = 9'b010000000,
        S_DONE  = 9'b100000000
    } fsm_t;

    fsm_t                  fsm_reg, fsm_next;
    logic [31:0]           tag_dev_reg   [ENTRIES];
    logic [31:0]           tag_page_reg  [ENTRIES];
    logic [CW-1:0]         valid_reg     [ENTRIES];
    bpc_pkg::line_state_t  line_reg      [ENTRIES];
    logic [IW-1:0]         ptr_reg;
    logic [DW-1:0]         dirty_total_reg;
    bpc_pkg::req_t         item_reg;
    logic [ENTRIES-1:0]    hitvec_reg, dirtyvec_reg, devvec_reg;
    logic [IW-1:0]         slot_reg, idx_reg;
    logic [31:0]           vic_dev_reg, vic_page_reg;
    logic [CW-1:0]         vic_cnt_reg, fill_cnt_reg;
    logic                  ok_reg;
    bpc_pkg::result_t      res_reg, res_next;
    logic                  res_valid_reg, res_valid_next;

    logic                  is_rw, is_write, hit, vic_dirty, page_ok;
    logic [IW-1:0]         hit_slot, ptr_adv;
    logic [DW-1:0]         pop_dirty, dirty_plan;
    logic [31:0]           fill32, xfer32, room;
    logic [31:0]           dirty_wide;

    assign pop      = (fsm_reg == S_IDLE) && q_valid;
    assign is_rw    = (item_reg.operation == bpc_pkg::OP_READ) ||
                      (item_reg.operation == bpc_pkg::OP_WRITE);
    assign is_write = (item_reg.operation == bpc_pkg::OP_WRITE);
    assign hit      = |hitvec_reg;
    assign vic_dirty = (line_reg[ptr_reg] == bpc_pkg::LS_DIRTY);
    assign page_ok  = (item_reg.page < item_reg.device_sectors);
    assign ptr_adv  = (32'(ptr_reg) + 32'd1 >= 32'(ENTRIES)) ? '0 : ptr_reg + IW'(1);

    always_comb
    begin
        hit_slot  = '0;
        pop_dirty = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (hitvec_reg[i])
            begin
                hit_slot = IW'(i);
            end
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            pop_dirty = pop_dirty + DW'(dirtyvec_reg[i]);
        end
    end

    always_comb
    begin
        fill32 = item_reg.device_sectors - item_reg.page;
        if (fill32 >= 32'(PAGE_SECTORS))
        begin
            fill32 = 32'(PAGE_SECTORS);
        end
        room   = 32'(PAGE_SECTORS) - 32'(item_reg.offset);
        xfer32 = (room > 32'(item_reg.num_sectors)) ? 32'(item_reg.num_sectors) : room;
    end

    // Dirty count after the whole request, known before its first result.
    always_comb
    begin
        dirty_plan = dirty_total_reg;
        if (is_rw)
        begin
            if (item_reg.num_sectors == 8'd0)
            begin
                dirty_plan = dirty_total_reg;
            end
            else if (hit)
            begin
                dirty_plan = dirty_total_reg +
                    DW'(is_write && (line_reg[hit_slot] != bpc_pkg::LS_DIRTY));
            end
            else
            begin
                dirty_plan = dirty_total_reg - DW'(vic_dirty) + DW'(is_write && page_ok);
            end
        end
        else
        begin
            dirty_plan = dirty_total_reg - pop_dirty;
        end
    end

    assign dirty_wide = 32'(dirty_total_reg);

    always_comb
    begin
        fsm_next                = fsm_reg;
        res_valid_next          = 1'b0;
        res_next.kind           = bpc_pkg::KIND_DONE;
        res_next.slot           = '0;
        res_next.out_device_id  = item_reg.disk_id;
        res_next.page_first     = '0;
        res_next.count          = '0;
        res_next.page_offset    = '0;
        res_next.dirty_entries  = dirty_wide[4:0];
        res_next.last           = 1'b0;
        unique case (fsm_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    fsm_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                fsm_next = S_PLAN;
            end
            S_PLAN:
            begin
                if (is_rw)
                begin
                    if (item_reg.num_sectors == 8'd0)
                    begin
                        fsm_next = S_ERR;
                    end
                    else if (hit)
                    begin
                        fsm_next = S_XFER;
                    end
                    else if (vic_dirty)
                    begin
                        fsm_next = S_VWB;
                    end
                    else
                    begin
                        fsm_next = page_ok ? S_FILL : S_ERR;
                    end
                end
                else if (item_reg.operation == bpc_pkg::OP_FLUSH)
                begin
                    fsm_next = S_WALK;
                end
                else
                begin
                    fsm_next = S_DONE;
                end
            end
            S_VWB:
            begin
                res_valid_next         = 1'b1;
                res_next.kind          = bpc_pkg::KIND_WRITE_BACK;
                res_next.slot          = 4'(slot_reg);
                res_next.out_device_id = vic_dev_reg;
                res_next.page_first    = vic_page_reg;
                res_next.count         = 4'(vic_cnt_reg);
                fsm_next               = ok_reg ? S_FILL : S_ERR;
            end
            S_FILL:
            begin
                res_valid_next      = 1'b1;
                res_next.kind       = bpc_pkg::KIND_FILL;
                res_next.slot       = 4'(slot_reg);
                res_next.page_first = item_reg.page;
                res_next.count      = 4'(fill_cnt_reg);
                fsm_next            = S_XFER;
            end
            S_ERR:
            begin
                res_valid_next = 1'b1;
                res_next.kind  = bpc_pkg::KIND_ERROR;
                res_next.last  = 1'b1;
                fsm_next       = S_IDLE;
            end
            S_XFER:
            begin
                res_valid_next       = 1'b1;
                res_next.kind        = bpc_pkg::KIND_TRANSFER;
                res_next.slot        = 4'(slot_reg);
                res_next.page_first  = item_reg.page;
                res_next.count       = xfer32[3:0];
                res_next.page_offset = 3'(item_reg.offset);
                res_next.last        = 1'b1;
                fsm_next             = S_IDLE;
            end
            S_WALK:
            begin
                if (dirtyvec_reg[idx_reg])
                begin
                    res_valid_next         = 1'b1;
                    res_next.kind          = bpc_pkg::KIND_WRITE_BACK;
                    res_next.slot          = 4'(idx_reg);
                    res_next.out_device_id = tag_dev_reg[idx_reg];
                    res_next.page_first    = tag_page_reg[idx_reg];
                    res_next.count         = 4'(valid_reg[idx_reg]);
                end
                if (32'(idx_reg) == 32'(ENTRIES - 1))
                begin
                    fsm_next = S_DONE;
                end
            end
            S_DONE:
            begin
                res_valid_next = 1'b1;
                res_next.kind  = bpc_pkg::KIND_DONE;
                res_next.last  = 1'b1;
                fsm_next       = S_IDLE;
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg         <= S_IDLE;
            res_valid_reg   <= 1'b0;
            ptr_reg         <= '0;
            dirty_total_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                tag_dev_reg[i]  <= '0;
                tag_page_reg[i] <= '0;
                valid_reg[i]    <= '0;
                line_reg[i]     <= bpc_pkg::LS_EMPTY;
            end
        end
        else
        begin
            fsm_reg       <= fsm_next;
            res_valid_reg <= res_valid_next;
            if (fsm_reg == S_PLAN)
            begin
                dirty_total_reg <= dirty_plan;
                if (is_rw && (item_reg.num_sectors != 8'd0) && !hit)
                begin
                    ptr_reg                <= ptr_adv;
                    tag_dev_reg[ptr_reg]   <= page_ok ? item_reg.disk_id : '0;
                    tag_page_reg[ptr_reg]  <= page_ok ? item_reg.page : '0;
                    valid_reg[ptr_reg]     <= page_ok ? CW'(fill32) : '0;
                    line_reg[ptr_reg]      <= page_ok ? bpc_pkg::LS_CLEAN : bpc_pkg::LS_EMPTY;
                end
                else if (item_reg.operation == bpc_pkg::OP_DROP)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (devvec_reg[i])
                        begin
                            tag_dev_reg[i]  <= '0;
                            tag_page_reg[i] <= '0;
                            valid_reg[i]    <= '0;
                            line_reg[i]     <= bpc_pkg::LS_EMPTY;
                        end
                    end
                end
            end
            if ((fsm_reg == S_XFER) && is_write)
            begin
                line_reg[slot_reg] <= bpc_pkg::LS_DIRTY;
            end
            if ((fsm_reg == S_WALK) && dirtyvec_reg[idx_reg])
            begin
                line_reg[idx_reg] <= bpc_pkg::LS_CLEAN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (pop)
        begin
            item_reg <= q_head;
        end
        if (fsm_reg == S_LOOK)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                hitvec_reg[i]   <= (line_reg[i] != bpc_pkg::LS_EMPTY) &&
                                   (tag_dev_reg[i] == item_reg.disk_id) &&
                                   (tag_page_reg[i] == item_reg.page);
                dirtyvec_reg[i] <= (line_reg[i] == bpc_pkg::LS_DIRTY) &&
                                   (tag_dev_reg[i] == item_reg.disk_id);
                devvec_reg[i]   <= (tag_dev_reg[i] == item_reg.disk_id);
            end
        end
        if (fsm_reg == S_PLAN)
        begin
            idx_reg      <= '0;
            slot_reg     <= hit ? hit_slot : ptr_reg;
            vic_dev_reg  <= tag_dev_reg[ptr_reg];
            vic_page_reg <= tag_page_reg[ptr_reg];
            vic_cnt_reg  <= valid_reg[ptr_reg];
            fill_cnt_reg <= CW'(fill32);
            ok_reg       <= page_ok;
        end
        if (fsm_reg == S_WALK)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == S_IDLE) |=> !res_valid_reg)
        else $error("result issued right after idle");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.kind == bpc_pkg::KIND_DONE)) |-> res_reg.last)
        else $error("done result without last");

    a_fill_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.kind == bpc_pkg::KIND_FILL)) |-> !res_reg.last)
        else $error("fill result marked last");

    a_dirty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(dirty_total_reg) <= 32'(ENTRIES))
        else $error("dirty count exceeds entries");

endmodule
